// ----- rtl/clock_synth_param_encoder_unit_defines.svh -----
// Assertion macros shared by the clock synthesizer parameter encoder RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef CLOCK_SYNTH_PARAM_ENCODER_UNIT_DEFINES_SVH
`define CLOCK_SYNTH_PARAM_ENCODER_UNIT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define CSPE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CSPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/cspe_pkg.sv -----
// Types and constants of the clock synthesizer parameter encoder.
// Used by cspe_div_stage and clock_synth_param_encoder_unit; no dependencies.
package cspe_pkg;

  localparam logic        ACTION_PLL  = 1'b0;
  localparam logic        ACTION_MS   = 1'b1;

  localparam logic [11:0] PLL_MIN     = 12'd15;
  localparam logic [11:0] PLL_MAX     = 12'd90;
  localparam logic [11:0] MS_MIN      = 12'd4;
  localparam logic [11:0] MS_MAX      = 12'd2048;
  localparam logic [1:0]  PORT_MAX    = 2'd2;

  localparam logic [17:0] P1_OFFSET   = 18'd512;
  localparam logic [7:0]  CTRL_BASE   = 8'h0F;
  localparam logic [7:0]  CTRL_PLL_B  = 8'h20;
  localparam logic [7:0]  CTRL_INT    = 8'h40;

  localparam int unsigned SCALE_SHIFT = 7;
  localparam int unsigned REM_W       = 20;
  localparam int unsigned WORD_W      = REM_W + SCALE_SHIFT;
  localparam int unsigned DIV_STEPS   = WORD_W;

  typedef struct packed {
    logic        action;
    logic        use_pll_b;
    logic [1:0]  port;
    logic [11:0] int_part;
    logic [20:0] frac_num;
    logic [20:0] frac_den;
  } cspe_in_t;

  typedef struct packed {
    logic        rejected;
    logic [17:0] p1;
    logic [19:0] p2;
    logic [19:0] p3;
    logic [7:0]  ctrl_byte;
    logic [63:0] param_regs;
  } cspe_out_t;

  // Request attributes that ride along with the division.
  typedef struct packed {
    logic             rejected;
    logic             action;
    logic             use_pll_b;
    logic [2:0]       rdiv;
    logic [11:0]      int_part;
    logic             num_zero;
    logic [REM_W-1:0] den;
  } cspe_side_t;

endpackage

// ----- rtl/cspe_div_stage.sv -----
// One registered step of the restoring divider that forms floor(128*b/c).
// Depends on cspe_pkg for the sideband type and the datapath widths.
module cspe_div_stage (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  cspe_pkg::cspe_side_t             in_side_i,
  input  logic [cspe_pkg::REM_W-1:0]       in_rem_i,
  input  logic [cspe_pkg::WORD_W-1:0]      in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output cspe_pkg::cspe_side_t             out_side_o,
  output logic [cspe_pkg::REM_W-1:0]       out_rem_o,
  output logic [cspe_pkg::WORD_W-1:0]      out_word_o
);

  logic                             valid_q;
  cspe_pkg::cspe_side_t             side_q;
  logic [cspe_pkg::REM_W-1:0]       rem_q, rem_d;
  logic [cspe_pkg::WORD_W-1:0]      word_q, word_d;
  logic [cspe_pkg::REM_W:0]         shifted;
  logic [cspe_pkg::REM_W:0]         diff;
  logic                             fits;

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  always_comb begin
    shifted = {in_rem_i, in_word_i[cspe_pkg::WORD_W-1]};
    fits    = shifted >= {1'b0, in_side_i.den};
    diff    = shifted - {1'b0, in_side_i.den};
    rem_d   = fits ? diff[cspe_pkg::REM_W-1:0] : shifted[cspe_pkg::REM_W-1:0];
    word_d  = {in_word_i[cspe_pkg::WORD_W-2:0], fits};
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      side_q <= in_side_i;
      rem_q  <= rem_d;
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_side_o  = side_q;
  assign out_rem_o   = rem_q;
  assign out_word_o  = word_q;

endmodule

// ----- rtl/clock_synth_param_encoder_unit.sv -----
// Top level of the clock synthesizer parameter encoder.
// Depends on cspe_pkg, cspe_div_stage and clock_synth_param_encoder_unit_defines.svh.
//
// Each request (PLL feedback or output multisynth divider a + b/c) is limit
// checked and encoded into P1/P2/P3, the eight parameter register bytes and,
// for multisynth requests, the clock control byte. The block takes one request
// per cycle when the output side does not stall, and each result passes through
// one input register, 27 one-bit steps of the pipelined restoring divider for
// floor(128*b/c), and one output register. The ready path runs combinationally
// back through every stage, so empty stages fill while a finished result waits.
// The R-divider register can be written in any cycle.
`include "clock_synth_param_encoder_unit_defines.svh"

module clock_synth_param_encoder_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [8:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cspe_pkg::cspe_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cspe_pkg::cspe_out_t out_data_o
);

  localparam int unsigned Steps = cspe_pkg::DIV_STEPS;

  logic [8:0]                 rdiv_codes_q;

  logic                       ent_valid_q;
  cspe_pkg::cspe_side_t       ent_side_q, ent_side_d;
  logic [cspe_pkg::WORD_W-1:0] ent_word_q;

  logic                       valid_w [Steps+1];
  logic                       ready_w [Steps+1];
  cspe_pkg::cspe_side_t       side_w  [Steps+1];
  logic [cspe_pkg::REM_W-1:0] rem_w   [Steps+1];
  logic [cspe_pkg::WORD_W-1:0] word_w [Steps+1];

  logic                       out_valid_q;
  cspe_pkg::cspe_out_t        out_q, out_d;
  logic                       bad_a;
  logic [2:0]                 rdiv_sel;
  logic [17:0]                quo;
  logic [17:0]                p1;

  logic                       out_rej;
  logic                       out_ok;
  logic                       fields_zero;
  logic                       ctrl_ok;
  logic                       last_stall;
  logic                       last_valid;
  cspe_pkg::cspe_side_t       last_side;

  // Configuration register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdiv_codes_q <= 9'd0;
    end else if (cfg_valid_i) begin
      rdiv_codes_q <= cfg_data_i;
    end
  end

  // Input stage: limit checks and divider operands.
  always_comb begin
    case (in_data_i.port)
      2'd0:    rdiv_sel = rdiv_codes_q[2:0];
      2'd1:    rdiv_sel = rdiv_codes_q[5:3];
      2'd2:    rdiv_sel = rdiv_codes_q[8:6];
      default: rdiv_sel = 3'd0;
    endcase

    if (in_data_i.action == cspe_pkg::ACTION_PLL) begin
      bad_a = (in_data_i.int_part < cspe_pkg::PLL_MIN) ||
              (in_data_i.int_part > cspe_pkg::PLL_MAX);
    end else begin
      bad_a = (in_data_i.port > cspe_pkg::PORT_MAX) ||
              (in_data_i.int_part < cspe_pkg::MS_MIN) ||
              (in_data_i.int_part > cspe_pkg::MS_MAX);
    end

    ent_side_d.rejected  = bad_a || (in_data_i.frac_den == 21'd0) ||
                           in_data_i.frac_den[20] || in_data_i.frac_num[20];
    ent_side_d.action    = in_data_i.action;
    ent_side_d.use_pll_b = in_data_i.use_pll_b;
    ent_side_d.rdiv      = (in_data_i.action == cspe_pkg::ACTION_MS) ? rdiv_sel : 3'd0;
    ent_side_d.int_part  = in_data_i.int_part;
    ent_side_d.num_zero  = (in_data_i.frac_num == 21'd0);
    ent_side_d.den       = in_data_i.frac_den[cspe_pkg::REM_W-1:0];
  end

  assign in_ready_o = !ent_valid_q || ready_w[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      ent_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ent_side_q <= ent_side_d;
      ent_word_q <= {in_data_i.frac_num[cspe_pkg::REM_W-1:0],
                     {cspe_pkg::SCALE_SHIFT{1'b0}}};
    end
  end

  assign valid_w[0] = ent_valid_q;
  assign side_w[0]  = ent_side_q;
  assign rem_w[0]   = '0;
  assign word_w[0]  = ent_word_q;

  // Divider pipeline, one quotient bit per stage.
  for (genvar k = 0; k < Steps; k++) begin : g_div
    cspe_div_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid_w[k]),
      .in_ready_o  (ready_w[k]),
      .in_side_i   (side_w[k]),
      .in_rem_i    (rem_w[k]),
      .in_word_i   (word_w[k]),
      .out_valid_o (valid_w[k+1]),
      .out_ready_i (ready_w[k+1]),
      .out_side_o  (side_w[k+1]),
      .out_rem_o   (rem_w[k+1]),
      .out_word_o  (word_w[k+1])
    );
  end

  // Output stage: P1 assembly and register byte packing.
  assign ready_w[Steps] = !out_valid_q || out_ready_i;

  always_comb begin
    quo = word_w[Steps][17:0];
    p1  = {side_w[Steps].int_part[10:0], {cspe_pkg::SCALE_SHIFT{1'b0}}} + quo -
          cspe_pkg::P1_OFFSET;

    out_d = '0;
    if (!side_w[Steps].rejected) begin
      out_d.p1 = p1;
      out_d.p2 = rem_w[Steps];
      out_d.p3 = side_w[Steps].den;
      if (side_w[Steps].action == cspe_pkg::ACTION_MS) begin
        out_d.ctrl_byte = cspe_pkg::CTRL_BASE |
                          (side_w[Steps].use_pll_b ? cspe_pkg::CTRL_PLL_B : 8'h00) |
                          (side_w[Steps].num_zero  ? cspe_pkg::CTRL_INT   : 8'h00);
      end
      out_d.param_regs = {side_w[Steps].den[15:8],
                          side_w[Steps].den[7:0],
                          1'b0, side_w[Steps].rdiv, 2'b00, p1[17:16],
                          p1[15:8],
                          p1[7:0],
                          side_w[Steps].den[19:16], rem_w[Steps][19:16],
                          rem_w[Steps][15:8],
                          rem_w[Steps][7:0]};
    end else begin
      out_d.rejected = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_w[Steps]) begin
      out_valid_q <= valid_w[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_w[Steps] && valid_w[Steps]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign out_rej     = out_valid_o && out_data_o.rejected;
  assign out_ok      = out_valid_o && !out_data_o.rejected;
  assign fields_zero = (out_data_o.p1 == 18'd0) && (out_data_o.p2 == 20'd0) &&
                       (out_data_o.p3 == 20'd0) && (out_data_o.ctrl_byte == 8'd0) &&
                       (out_data_o.param_regs == 64'd0);
  assign ctrl_ok     = (out_data_o.ctrl_byte == 8'd0) ||
                       (out_data_o.ctrl_byte[4:0] == 5'h0F);
  assign last_stall  = valid_w[Steps] && !ready_w[Steps];
  assign last_valid  = valid_w[Steps];
  assign last_side   = side_w[Steps];

  `CSPE_ASSERT(a_rej_zero, clk_i, rst_ni, !out_rej || fields_zero, "rejected result not cleared")
  `CSPE_ASSERT(a_rem_below_den, clk_i, rst_ni, !out_ok || (out_data_o.p2 < out_data_o.p3), "p2 >= p3")
  `CSPE_ASSERT(a_ctrl_form, clk_i, rst_ni, !out_ok || ctrl_ok, "clock control byte malformed")
  `CSPE_ASSERT_NEXT(a_last_hold, clk_i, rst_ni, last_stall, last_valid && $stable(last_side), "lost")

endmodule
